/* rtl/spq_pkg.sv */
// Shared types and constants for the stable priority queue.
package spq_pkg;

  // Default sizes, handed to the top-level parameters
  localparam int unsigned CAPACITY_DEF     = 16;
  localparam int unsigned PRIO_BITS_DEF    = 8;
  localparam int unsigned PAYLOAD_BITS_DEF = 16;

  // Request field width and request codes
  localparam int unsigned REQ_W = 2;
  localparam logic [REQ_W-1:0] REQ_ENQ = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DEQ = 2'd1;

  // Depth of the command queue between front and back end
  localparam int unsigned CMDQ_DEPTH = 2;

  // Classified operation
  typedef enum logic [1:0] {
    OP_ENQ,
    OP_DEQ,
    OP_QRY
  } spq_op_t;

  // Command handed from the front end to the back end
  typedef struct packed {
    logic    vld;
    spq_op_t op;
  } spq_cmd_t;

endpackage

/* rtl/spq_front.sv */
// Front end: accepts requests, classifies them and queues them for the back end.
module spq_front #(
  parameter int unsigned PRIO_BITS    = spq_pkg::PRIO_BITS_DEF,
  parameter int unsigned PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [spq_pkg::REQ_W-1:0]   in_req_type,
  input  logic [PAYLOAD_BITS-1:0]     in_item_payload,
  input  logic [PRIO_BITS-1:0]        in_item_priority,
  output spq_pkg::spq_cmd_t           cmd,
  output logic [PAYLOAD_BITS-1:0]     cmd_payload,
  output logic [PRIO_BITS-1:0]        cmd_priority
);
  import spq_pkg::*;

  localparam int unsigned PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(CMDQ_DEPTH + 1);

  spq_op_t                 op_q  [CMDQ_DEPTH];
  logic [PAYLOAD_BITS-1:0] pay_q [CMDQ_DEPTH];
  logic [PRIO_BITS-1:0]    pri_q [CMDQ_DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic    push;
  logic    pop;
  spq_op_t op_in;

  // Classify: codes 2 and 3, which have no named request code, both behave as a query
  always_comb begin
    case (in_req_type)
      REQ_ENQ: op_in = OP_ENQ;
      REQ_DEQ: op_in = OP_DEQ;
      default: op_in = OP_QRY;
    endcase
  end

  assign busy = (cnt_r == CNT_W'(CMDQ_DEPTH));
  assign push = start && !busy;
  // Back end retires one command every cycle while the queue is not empty
  assign pop  = (cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      op_q[wr_ptr_r]  <= op_in;
      pay_q[wr_ptr_r] <= in_item_payload;
      pri_q[wr_ptr_r] <= in_item_priority;
    end
  end

  assign cmd.vld      = pop;
  assign cmd.op       = op_q[rd_ptr_r];
  assign cmd_payload  = pay_q[rd_ptr_r];
  assign cmd_priority = pri_q[rd_ptr_r];

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CMDQ_DEPTH))
    else $error("command queue count overflow");

  a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("accepted item not queued");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.vld |-> (cnt_r != '0))
    else $error("command issued from empty queue");

endmodule

/* rtl/spq_back.sv */
// Back end: sorted slot array that executes one command per cycle and reports the result.
module spq_back #(
  parameter int unsigned CAPACITY     = spq_pkg::CAPACITY_DEF,
  parameter int unsigned PRIO_BITS    = spq_pkg::PRIO_BITS_DEF,
  parameter int unsigned PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF,
  localparam int unsigned CNT_W       = $clog2(CAPACITY + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  spq_pkg::spq_cmd_t       cmd,
  input  logic [PAYLOAD_BITS-1:0] cmd_payload,
  input  logic [PRIO_BITS-1:0]    cmd_priority,
  output logic                    out_valid,
  output logic                    out_deq_valid,
  output logic [PAYLOAD_BITS-1:0] out_deq_payload,
  output logic [PAYLOAD_BITS-1:0] out_head_payload,
  output logic [PAYLOAD_BITS-1:0] out_tail_payload,
  output logic [CNT_W-1:0]        out_entry_count,
  output logic                    out_is_empty,
  output logic                    out_enq_dropped
);
  import spq_pkg::*;

  logic [PRIO_BITS-1:0]    prio_r [CAPACITY];
  logic [PAYLOAD_BITS-1:0] pay_r  [CAPACITY];
  logic [PRIO_BITS-1:0]    prio_nxt [CAPACITY];
  logic [PAYLOAD_BITS-1:0] pay_nxt  [CAPACITY];

  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [PAYLOAD_BITS-1:0] tail_r, tail_nxt;
  logic                    out_valid_r, deq_valid_r, dropped_r;
  logic [PAYLOAD_BITS-1:0] deq_pay_r;

  logic [CAPACITY-1:0] le;   // occupied and served no later than the new item
  logic [CAPACITY-1:0] gt;   // occupied and served after the new item
  logic full, empty, do_enq, do_deq;

  assign full   = (count_r == CNT_W'(CAPACITY));
  assign empty  = (count_r == '0);
  assign do_enq = cmd.vld && (cmd.op == OP_ENQ) && !full;
  assign do_deq = cmd.vld && (cmd.op == OP_DEQ) && !empty;

  // Every cell compares against the incoming priority at once
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic occ;
    assign occ   = (CNT_W'(i) < count_r);
    assign le[i] = occ && (prio_r[i] <= cmd_priority);
    assign gt[i] = occ && (prio_r[i] >  cmd_priority);

    always_comb begin
      prio_nxt[i] = prio_r[i];
      pay_nxt[i]  = pay_r[i];
      if (do_enq) begin
        if (le[i]) begin
          // hold: stays ahead of the new item
        end else if (i == 0 || le[(i == 0) ? 0 : i - 1]) begin
          prio_nxt[i] = cmd_priority;
          pay_nxt[i]  = cmd_payload;
        end else begin
          prio_nxt[i] = prio_r[(i == 0) ? 0 : i - 1];
          pay_nxt[i]  = pay_r[(i == 0) ? 0 : i - 1];
        end
      end else if (do_deq && (i < CAPACITY - 1)) begin
        prio_nxt[i] = prio_r[(i < CAPACITY - 1) ? i + 1 : i];
        pay_nxt[i]  = pay_r[(i < CAPACITY - 1) ? i + 1 : i];
      end
    end

    always_ff @(posedge clk) begin
      prio_r[i] <= prio_nxt[i];
      pay_r[i]  <= pay_nxt[i];
    end
  end

  always_comb begin
    count_nxt = count_r;
    tail_nxt  = tail_r;
    if (do_enq) begin
      count_nxt = count_r + 1'b1;
      // New item lands at the back when nothing stored follows it
      if (!(|gt)) begin
        tail_nxt = cmd_payload;
      end
    end else if (do_deq) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= cmd.vld;
    end
  end

  always_ff @(posedge clk) begin
    tail_r      <= tail_nxt;
    deq_valid_r <= do_deq;
    deq_pay_r   <= do_deq ? pay_r[0] : '0;
    dropped_r   <= cmd.vld && (cmd.op == OP_ENQ) && full;
  end

  assign out_valid        = out_valid_r;
  assign out_deq_valid    = deq_valid_r;
  assign out_deq_payload  = deq_pay_r;
  assign out_entry_count  = count_r;
  assign out_is_empty     = (count_r == '0);
  assign out_head_payload = (count_r == '0) ? '0 : pay_r[0];
  assign out_tail_payload = (count_r == '0) ? '0 : tail_r;
  assign out_enq_dropped  = dropped_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_enq_dropped |-> (out_valid && count_r == CNT_W'(CAPACITY)))
    else $error("enqueue dropped while not full");

  a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
    do_deq |=> (count_r == $past(count_r) - 1'b1) && out_deq_valid)
    else $error("dequeue did not retire an entry");

  a_result_follows_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.vld |=> out_valid)
    else $error("command produced no result");

endmodule

/* rtl/stable_priority_queue.sv */
// Top level of the stable priority queue: front end, command queue and sorted back end.
//
// Bounded priority queue of CAPACITY entries, lower priority numbers served first,
// equal priorities in arrival order. Drive start with a request (0 enqueue,
// 1 dequeue, 2 or 3 query); it is taken at a clock edge where busy is low. Every
// request yields exactly one result. out_valid rises at the edge after the accepting
// edge and stays high for one cycle. The result is taken at the edge after that. The
// receiver cannot stall it, so sample it then. The back end retires one request per
// clock: each slot of the sorted array compares its priority with the new one in
// parallel and shifts by one in the same cycle, so a steady rate of one item per
// cycle is sustained and busy stays low. busy rises only if the two-entry command
// queue between the halves fills. An enqueue to a full queue is dropped and flagged
// with out_enq_dropped. Head, tail, count and empty reflect the queue after the
// request; head and tail read 0 when empty.
module stable_priority_queue #(
  parameter int unsigned CAPACITY     = spq_pkg::CAPACITY_DEF,
  parameter int unsigned PRIO_BITS    = spq_pkg::PRIO_BITS_DEF,
  parameter int unsigned PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF,
  localparam int unsigned CNT_W       = $clog2(CAPACITY + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [spq_pkg::REQ_W-1:0] in_req_type,
  input  logic [PAYLOAD_BITS-1:0]   in_item_payload,
  input  logic [PRIO_BITS-1:0]      in_item_priority,
  output logic                      out_valid,
  output logic                      out_deq_valid,
  output logic [PAYLOAD_BITS-1:0]   out_deq_payload,
  output logic [PAYLOAD_BITS-1:0]   out_head_payload,
  output logic [PAYLOAD_BITS-1:0]   out_tail_payload,
  output logic [CNT_W-1:0]          out_entry_count,
  output logic                      out_is_empty,
  output logic                      out_enq_dropped
);
  import spq_pkg::*;

  spq_cmd_t                cmd;
  logic [PAYLOAD_BITS-1:0] cmd_payload;
  logic [PRIO_BITS-1:0]    cmd_priority;

  // Accept and classify requests, buffer them ahead of the slot array
  spq_front #(
    .PRIO_BITS    (PRIO_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_item_payload  (in_item_payload),
    .in_item_priority (in_item_priority),
    .cmd              (cmd),
    .cmd_payload      (cmd_payload),
    .cmd_priority     (cmd_priority)
  );

  // Execute against the sorted slots and register the result
  spq_back #(
    .CAPACITY     (CAPACITY),
    .PRIO_BITS    (PRIO_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cmd_payload      (cmd_payload),
    .cmd_priority     (cmd_priority),
    .out_valid        (out_valid),
    .out_deq_valid    (out_deq_valid),
    .out_deq_payload  (out_deq_payload),
    .out_head_payload (out_head_payload),
    .out_tail_payload (out_tail_payload),
    .out_entry_count  (out_entry_count),
    .out_is_empty     (out_is_empty),
    .out_enq_dropped  (out_enq_dropped)
  );

endmodule
